// ----- design/spool_pkg.sv -----
// Package for the slot pool with ordered live list: sizes, link encoding, request and
// response types, command and status codes, and the link memory write port.
// Depends on nothing; every other design file uses it by scoped names.
package spool_pkg;

    localparam int SLOTS    = 32;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int LINK_W   = $clog2(SLOTS + 1);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int TAG_W    = 32;
    localparam int CMD_W    = 3;
    localparam int FSLOT_W  = 5;
    localparam int LIVE_W   = 6;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TAG_W-1:0]  tag_t;

    // The link value for "no slot".
    localparam link_t NIL = link_t'(SLOTS);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC    = 3'd0,
        CMD_FREE     = 3'd1,
        CMD_MOVE     = 3'd2,
        CMD_FIND     = 3'd3,
        CMD_FREE_ALL = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NOT_LIVE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [FSLOT_W-1:0] slot;
        tag_t               search_tag;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [FSLOT_W-1:0] result_slot;
        tag_t               result_tag;
        logic [LIVE_W-1:0]  live_count;
    } rsp_t;

    typedef struct packed {
        logic  next_we;
        slot_t next_addr;
        link_t next_data;
        logic  prev_we;
        slot_t prev_addr;
        link_t prev_data;
    } link_wr_t;

    function automatic logic is_slot(input link_t l);
        return l < NIL;
    endfunction

    function automatic link_t to_link(input slot_t s);
        return link_t'(s);
    endfunction

    function automatic slot_t to_slot(input link_t l);
        return l[SLOT_W-1:0];
    endfunction

endpackage

// ----- design/spool_link_mem.sv -----
// Next and previous link memories of the slot pool, one write port each and a shared
// registered read port. Entries never written read as their reset links.
// Depends on spool_pkg.
module spool_link_mem (
    input  logic                clk,
    input  logic                rst_n,
    input  spool_pkg::link_wr_t wr,
    input  spool_pkg::slot_t    raddr,
    output spool_pkg::link_t    next_rdata,
    output spool_pkg::link_t    prev_rdata
);

    spool_pkg::link_t                  next_mem [spool_pkg::SLOTS];
    spool_pkg::link_t                  prev_mem [spool_pkg::SLOTS];
    logic [spool_pkg::SLOTS-1:0]       next_seen_reg;
    logic [spool_pkg::SLOTS-1:0]       prev_seen_reg;
    spool_pkg::link_t                  next_q_reg;
    spool_pkg::link_t                  prev_q_reg;
    logic                              next_ok_reg;
    logic                              prev_ok_reg;
    spool_pkg::slot_t                  raddr_reg;
    logic                              next_hit;
    logic                              prev_hit;

    assign next_hit = wr.next_we && (wr.next_addr == raddr);
    assign prev_hit = wr.prev_we && (wr.prev_addr == raddr);

    always_ff @(posedge clk)
    begin
        if (wr.next_we)
        begin
            next_mem[wr.next_addr] <= wr.next_data;
        end
        if (wr.prev_we)
        begin
            prev_mem[wr.prev_addr] <= wr.prev_data;
        end
        if (next_hit)
        begin
            next_q_reg <= wr.next_data;
        end
        else
        begin
            next_q_reg <= next_mem[raddr];
        end
        if (prev_hit)
        begin
            prev_q_reg <= wr.prev_data;
        end
        else
        begin
            prev_q_reg <= prev_mem[raddr];
        end
        raddr_reg <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seen_reg <= '0;
            prev_seen_reg <= '0;
            next_ok_reg   <= 1'b0;
            prev_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr.next_we)
            begin
                next_seen_reg[wr.next_addr] <= 1'b1;
            end
            if (wr.prev_we)
            begin
                prev_seen_reg[wr.prev_addr] <= 1'b1;
            end
            next_ok_reg <= next_seen_reg[raddr] | next_hit;
            prev_ok_reg <= prev_seen_reg[raddr] | prev_hit;
        end
    end

    always_comb
    begin
        if (next_ok_reg)
        begin
            next_rdata = next_q_reg;
        end
        else
        begin
            next_rdata = spool_pkg::to_link(raddr_reg) + spool_pkg::link_t'(1);
        end
        if (prev_ok_reg)
        begin
            prev_rdata = prev_q_reg;
        end
        else if (raddr_reg == '0)
        begin
            prev_rdata = spool_pkg::NIL;
        end
        else
        begin
            prev_rdata = spool_pkg::to_link(raddr_reg) - spool_pkg::link_t'(1);
        end
    end

endmodule

// ----- design/spool_tag_mem.sv -----
// Tag memory of the slot pool: one write port and one registered read port.
// Contents are undefined until written. Depends on spool_pkg.
module spool_tag_mem (
    input  logic             clk,
    input  logic             we,
    input  spool_pkg::slot_t waddr,
    input  spool_pkg::tag_t  wdata,
    input  spool_pkg::slot_t raddr,
    output spool_pkg::tag_t  rdata
);

    spool_pkg::tag_t mem [spool_pkg::SLOTS];
    spool_pkg::tag_t q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            q_reg <= wdata;
        end
        else
        begin
            q_reg <= mem[raddr];
        end
    end

    assign rdata = q_reg;

endmodule

// ----- design/slot_pool_with_ordered_live_list.sv -----
// Top level of the slot pool with an ordered live list: command sequencer, list heads,
// counters and live flags. Depends on spool_pkg, spool_link_mem and spool_tag_mem.
//
// A request on the request port is taken at a rising edge where start is high and busy
// is low. Exactly one response follows on the response port, marked by done for one
// cycle; the receiver must take it then, as nothing holds it. Busy stays low while a
// response is shown, so the next request may be taken in that same cycle.
// The link memory read-modify-write sequence (one read port, one write port per link
// memory) sets the steps: allocate goes through S_ALLOC, free through S_FREE_UNL and
// S_FREE_FIN, move to head through S_MOVE_UNL and S_MOVE_FIN, find stays in S_FIND
// per slot visited, free all repeats the two free states per live slot, and every
// refused or trivial request (pool full, slot not live, empty list, move of the head,
// unknown command) is answered from idle. Busy is high while out of idle. Find visits
// one slot per cycle through the registered read of the tag and next link memories.
// Reset is asynchronous and active low. It needs no clearing pass: the link memories
// carry a written flag per entry and read as the initial free list until written.
module slot_pool_with_ordered_live_list (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  spool_pkg::req_t request,
    output logic            done,
    output spool_pkg::rsp_t response
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_ALLOC    = 7'b0000010,
        S_FREE_UNL = 7'b0000100,
        S_FREE_FIN = 7'b0001000,
        S_MOVE_UNL = 7'b0010000,
        S_MOVE_FIN = 7'b0100000,
        S_FIND     = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    spool_pkg::link_t            fh_reg, fh_next;
    spool_pkg::link_t            head_reg, head_next;
    spool_pkg::link_t            tail_reg, tail_next;
    spool_pkg::cnt_t             total_reg, total_next;
    spool_pkg::tag_t             ctr_reg, ctr_next;
    logic [spool_pkg::SLOTS-1:0] live_reg, live_next;
    logic                        all_reg, all_next;
    logic                        done_reg, done_next;
    spool_pkg::slot_t            cur_reg, cur_next;
    spool_pkg::tag_t             want_reg, want_next;
    spool_pkg::rsp_t             rsp_reg, rsp_next;

    spool_pkg::link_wr_t         lw;
    spool_pkg::slot_t            rd_addr;
    spool_pkg::link_t            next_q;
    spool_pkg::link_t            prev_q;
    logic                        tag_we;
    spool_pkg::tag_t             tag_q;
    spool_pkg::slot_t            req_slot;
    spool_pkg::status_t          r_status;
    spool_pkg::slot_t            r_slot;
    spool_pkg::tag_t             r_tag;

    spool_link_mem u_link (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (lw),
        .raddr      (rd_addr),
        .next_rdata (next_q),
        .prev_rdata (prev_q)
    );

    spool_tag_mem u_tag (
        .clk   (clk),
        .we    (tag_we),
        .waddr (cur_reg),
        .wdata (ctr_reg),
        .raddr (rd_addr),
        .rdata (tag_q)
    );

    assign req_slot = spool_pkg::SLOT_W'(request.slot);

    always_comb
    begin
        state_next = state_reg;
        fh_next    = fh_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        total_next = total_reg;
        ctr_next   = ctr_reg;
        live_next  = live_reg;
        all_next   = all_reg;
        cur_next   = cur_reg;
        want_next  = want_reg;
        done_next  = 1'b0;
        lw         = '0;
        rd_addr    = cur_reg;
        tag_we     = 1'b0;
        r_status   = spool_pkg::ST_OK;
        r_slot     = '0;
        r_tag      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (request.command)
                        spool_pkg::CMD_ALLOC:
                        begin
                            if (!spool_pkg::is_slot(fh_reg))
                            begin
                                r_status  = spool_pkg::ST_FULL;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr      = spool_pkg::to_slot(fh_reg);
                                cur_next     = spool_pkg::to_slot(fh_reg);
                                lw.next_we   = spool_pkg::is_slot(tail_reg);
                                lw.next_addr = spool_pkg::to_slot(tail_reg);
                                lw.next_data = fh_reg;
                                lw.prev_we   = 1'b1;
                                lw.prev_addr = spool_pkg::to_slot(fh_reg);
                                lw.prev_data = tail_reg;
                                state_next   = S_ALLOC;
                            end
                        end
                        spool_pkg::CMD_FREE:
                        begin
                            if (!live_reg[req_slot])
                            begin
                                r_status  = spool_pkg::ST_NOT_LIVE;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr      = req_slot;
                                cur_next     = req_slot;
                                all_next     = 1'b0;
                                lw.prev_we   = spool_pkg::is_slot(fh_reg);
                                lw.prev_addr = spool_pkg::to_slot(fh_reg);
                                lw.prev_data = spool_pkg::to_link(req_slot);
                                state_next   = S_FREE_UNL;
                            end
                        end
                        spool_pkg::CMD_FREE_ALL:
                        begin
                            if (!spool_pkg::is_slot(head_reg))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr      = spool_pkg::to_slot(head_reg);
                                cur_next     = spool_pkg::to_slot(head_reg);
                                all_next     = 1'b1;
                                lw.prev_we   = spool_pkg::is_slot(fh_reg);
                                lw.prev_addr = spool_pkg::to_slot(fh_reg);
                                lw.prev_data = head_reg;
                                state_next   = S_FREE_UNL;
                            end
                        end
                        spool_pkg::CMD_MOVE:
                        begin
                            if (!live_reg[req_slot])
                            begin
                                r_status  = spool_pkg::ST_NOT_LIVE;
                                done_next = 1'b1;
                            end
                            else if (spool_pkg::to_link(req_slot) == head_reg)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr      = req_slot;
                                cur_next     = req_slot;
                                lw.prev_we   = 1'b1;
                                lw.prev_addr = spool_pkg::to_slot(head_reg);
                                lw.prev_data = spool_pkg::to_link(req_slot);
                                state_next   = S_MOVE_UNL;
                            end
                        end
                        spool_pkg::CMD_FIND:
                        begin
                            want_next = request.search_tag;
                            if (!spool_pkg::is_slot(head_reg))
                            begin
                                r_status  = spool_pkg::ST_NOT_FOUND;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = spool_pkg::to_slot(head_reg);
                                cur_next   = spool_pkg::to_slot(head_reg);
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                lw.next_we   = 1'b1;
                lw.next_addr = cur_reg;
                lw.next_data = spool_pkg::NIL;
                lw.prev_we   = spool_pkg::is_slot(next_q);
                lw.prev_addr = spool_pkg::to_slot(next_q);
                lw.prev_data = spool_pkg::NIL;
                tag_we       = 1'b1;
                fh_next      = next_q;
                if (!spool_pkg::is_slot(head_reg))
                begin
                    head_next = spool_pkg::to_link(cur_reg);
                end
                tail_next         = spool_pkg::to_link(cur_reg);
                live_next[cur_reg] = 1'b1;
                ctr_next          = ctr_reg + spool_pkg::tag_t'(1);
                total_next        = total_reg + spool_pkg::cnt_t'(1);
                r_slot            = cur_reg;
                r_tag             = ctr_reg;
                done_next         = 1'b1;
                state_next        = S_IDLE;
            end
            S_FREE_UNL, S_MOVE_UNL:
            begin
                lw.next_we   = spool_pkg::is_slot(prev_q);
                lw.next_addr = spool_pkg::to_slot(prev_q);
                lw.next_data = next_q;
                lw.prev_we   = spool_pkg::is_slot(next_q);
                lw.prev_addr = spool_pkg::to_slot(next_q);
                lw.prev_data = prev_q;
                if (!spool_pkg::is_slot(prev_q))
                begin
                    head_next = next_q;
                end
                if (!spool_pkg::is_slot(next_q))
                begin
                    tail_next = prev_q;
                end
                if (state_reg == S_FREE_UNL)
                begin
                    state_next = S_FREE_FIN;
                end
                else
                begin
                    state_next = S_MOVE_FIN;
                end
            end
            S_FREE_FIN:
            begin
                lw.next_we         = 1'b1;
                lw.next_addr       = cur_reg;
                lw.next_data       = fh_reg;
                lw.prev_we         = 1'b1;
                lw.prev_addr       = cur_reg;
                fh_next            = spool_pkg::to_link(cur_reg);
                live_next[cur_reg] = 1'b0;
                if (total_reg != '0)
                begin
                    total_next = total_reg - spool_pkg::cnt_t'(1);
                end
                if (all_reg && spool_pkg::is_slot(head_reg))
                begin
                    // The freed slot becomes the free head, under the next slot to go.
                    lw.prev_data = head_reg;
                    rd_addr      = spool_pkg::to_slot(head_reg);
                    cur_next     = spool_pkg::to_slot(head_reg);
                    state_next   = S_FREE_UNL;
                end
                else
                begin
                    lw.prev_data = spool_pkg::NIL;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_MOVE_FIN:
            begin
                lw.next_we   = 1'b1;
                lw.next_addr = cur_reg;
                lw.next_data = head_reg;
                lw.prev_we   = 1'b1;
                lw.prev_addr = cur_reg;
                lw.prev_data = spool_pkg::NIL;
                head_next    = spool_pkg::to_link(cur_reg);
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            S_FIND:
            begin
                if (tag_q == want_reg)
                begin
                    r_slot     = cur_reg;
                    r_tag      = tag_q;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!spool_pkg::is_slot(next_q))
                begin
                    r_status   = spool_pkg::ST_NOT_FOUND;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr  = spool_pkg::to_slot(next_q);
                    cur_next = spool_pkg::to_slot(next_q);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_next             = rsp_reg;
        if (done_next)
        begin
            rsp_next.status      = r_status;
            rsp_next.result_slot = spool_pkg::FSLOT_W'(r_slot);
            rsp_next.result_tag  = r_tag;
            rsp_next.live_count  = spool_pkg::LIVE_W'(total_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fh_reg    <= '0;
            head_reg  <= spool_pkg::NIL;
            tail_reg  <= spool_pkg::NIL;
            total_reg <= '0;
            ctr_reg   <= '0;
            live_reg  <= '0;
            all_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fh_reg    <= fh_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            total_reg <= total_next;
            ctr_reg   <= ctr_next;
            live_reg  <= live_next;
            all_reg   <= all_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        want_reg <= want_next;
        rsp_reg  <= rsp_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = rsp_reg;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for slot_pool_with_ordered_live_list: a directed table, then
// random command mixes, each response checked against a behavioural model or typed row.
// Depends on spool_pkg and the design files; it reads and writes no files.
`timescale 1ns / 100ps

module testbench;

    import spool_pkg::*;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    typedef struct {
        req_t rq;
        logic typed;
        rsp_t want;
    } plan_row_t;

    typedef struct {
        int   seq;
        rsp_t rsp;
    } due_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t request;
    rsp_t response;

    link_t chain_next [SLOTS];
    link_t chain_prev [SLOTS];
    logic  slot_live  [SLOTS];
    tag_t  slot_stamp [SLOTS];
    link_t free_top;
    link_t live_first;
    link_t live_last;
    cnt_t  live_n;
    tag_t  stamp_next;

    plan_row_t plan [$];
    due_t      outcomes_due [$];
    int        seq_no;
    int        mismatches;
    int        responses_seen;
    int        status_seen [4];
    int        free_all_seen;
    int        quiet_left;

    slot_pool_with_ordered_live_list dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic void pool_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            chain_next[i] = link_t'(i + 1);
            chain_prev[i] = (i == 0) ? NIL : link_t'(i - 1);
            slot_live[i]  = 1'b0;
            slot_stamp[i] = '0;
        end
        free_top   = '0;
        live_first = NIL;
        live_last  = NIL;
        live_n     = '0;
        stamp_next = '0;
    endfunction

    function automatic void unlink_slot(input link_t s);
        link_t p;
        link_t n;
        p = chain_prev[s];
        n = chain_next[s];
        if (p < NIL)
            chain_next[p] = n;
        else
            live_first = n;
        if (n < NIL)
            chain_prev[n] = p;
        else
            live_last = p;
    endfunction

    function automatic void release_slot(input link_t s);
        unlink_slot(s);
        if (free_top < NIL)
            chain_prev[free_top] = s;
        chain_next[s] = free_top;
        chain_prev[s] = NIL;
        free_top      = s;
        slot_live[s]  = 1'b0;
        if (live_n > 0)
            live_n = live_n - 1'b1;
    endfunction

    // Applies one request to the model pool and returns the response it must produce.
    function automatic rsp_t pool_outcome(input req_t rq);
        rsp_t  o;
        link_t a;
        link_t s;
        link_t cur;
        int    steps;
        logic  hit;
        o        = '0;
        o.status = ST_OK;
        s        = link_t'(rq.slot);
        case (rq.command)
            CMD_ALLOC:
            begin
                if (free_top >= NIL)
                    o.status = ST_FULL;
                else
                begin
                    a        = free_top;
                    free_top = chain_next[a];
                    if (free_top < NIL)
                        chain_prev[free_top] = NIL;
                    chain_prev[a] = live_last;
                    if (live_first >= NIL)
                        live_first = a;
                    else
                        chain_next[live_last] = a;
                    live_last     = a;
                    chain_next[a] = NIL;
                    slot_live[a]  = 1'b1;
                    slot_stamp[a] = stamp_next;
                    stamp_next    = stamp_next + 1'b1;
                    live_n        = live_n + 1'b1;
                    o.result_slot = a[FSLOT_W-1:0];
                    o.result_tag  = slot_stamp[a];
                end
            end
            CMD_FREE:
            begin
                if (!slot_live[s])
                    o.status = ST_NOT_LIVE;
                else
                    release_slot(s);
            end
            CMD_MOVE:
            begin
                if (!slot_live[s])
                    o.status = ST_NOT_LIVE;
                else if (chain_prev[s] < NIL)
                begin
                    unlink_slot(s);
                    if (live_first < NIL)
                        chain_prev[live_first] = s;
                    chain_next[s] = live_first;
                    chain_prev[s] = NIL;
                    live_first    = s;
                    if (live_last >= NIL)
                        live_last = s;
                end
            end
            CMD_FIND:
            begin
                o.status = ST_NOT_FOUND;
                cur      = live_first;
                steps    = 0;
                hit      = 1'b0;
                while (cur < NIL && steps < SLOTS && !hit)
                begin
                    if (slot_stamp[cur] == rq.search_tag)
                    begin
                        hit           = 1'b1;
                        o.status      = ST_OK;
                        o.result_slot = cur[FSLOT_W-1:0];
                        o.result_tag  = slot_stamp[cur];
                    end
                    else
                    begin
                        cur   = chain_next[cur];
                        steps = steps + 1;
                    end
                end
            end
            CMD_FREE_ALL:
            begin
                steps = 0;
                while (live_first < NIL && steps < SLOTS)
                begin
                    release_slot(live_first);
                    steps = steps + 1;
                end
            end
            default:
            begin
            end
        endcase
        o.live_count = live_n;
        return o;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd, input int slot,
                                    input tag_t tag, input logic typed,
                                    input status_t st, input int rslot,
                                    input tag_t rtag, input int count);
        plan_row_t r;
        r.rq.command          = cmd;
        r.rq.slot             = FSLOT_W'(slot);
        r.rq.search_tag       = tag;
        r.typed               = typed;
        r.want.status         = st;
        r.want.result_slot    = FSLOT_W'(rslot);
        r.want.result_tag     = rtag;
        r.want.live_count     = LIVE_W'(count);
        plan.push_back(r);
    endfunction

    function automatic int pick_live();
        int picks [$];
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i])
                picks.push_back(i);
        if (picks.size() == 0)
            return -1;
        return picks[$urandom_range(0, picks.size() - 1)];
    endfunction

    function automatic req_t pick_request();
        req_t rq;
        int   roll;
        int   victim;
        rq.command    = CMD_ALLOC;
        rq.slot       = FSLOT_W'($urandom_range(0, SLOTS - 1));
        rq.search_tag = $urandom();
        roll          = $urandom_range(0, 99);
        victim        = pick_live();
        if (roll < 30 || roll >= 95)
            rq.command = CMD_ALLOC;
        else if (roll < 50)
        begin
            rq.command = CMD_FREE;
            if (victim >= 0)
                rq.slot = FSLOT_W'(victim);
        end
        else if (roll < 62)
        begin
            rq.command = CMD_MOVE;
            if (victim >= 0)
                rq.slot = ($urandom_range(0, 3) == 0) ? live_first[FSLOT_W-1:0]
                                                       : FSLOT_W'(victim);
        end
        else if (roll < 77)
        begin
            rq.command = CMD_FIND;
            case ($urandom_range(0, 4))
                0, 1, 2: if (victim >= 0) rq.search_tag = slot_stamp[victim];
                3:       rq.search_tag = stamp_next - tag_t'($urandom_range(0, 2));
                default:
                begin
                end
            endcase
        end
        else if (roll < 79)
            rq.command = CMD_FREE_ALL;
        else if (roll < 86)
            rq.command = CMD_FREE;
        else if (roll < 91)
            rq.command = CMD_MOVE;
        else
        begin
            case ($urandom_range(0, 2))
                0:       rq.command = CMD_SPARE_A;
                1:       rq.command = CMD_SPARE_B;
                default: rq.command = CMD_SPARE_C;
            endcase
        end
        return rq;
    endfunction

    function automatic int idle_gap();
        int roll;
        if (quiet_left > 0)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic tally(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic send(input req_t rq, input logic typed, input rsp_t fixed);
        int   gap;
        rsp_t p;
        due_t d;
        gap = idle_gap();
        repeat (gap)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        p = pool_outcome(rq);
        status_seen[int'(p.status)]++;
        if (rq.command == CMD_FREE_ALL)
            free_all_seen++;
        d.seq = seq_no;
        d.rsp = typed ? fixed : p;
        outcomes_due.push_back(d);
        seq_no++;
        @(negedge clk);
    endtask

    task automatic drain();
        if (outcomes_due.size() != 0)
        begin
            start <= 1'b0;
            while (outcomes_due.size() != 0)
                @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        due_t want;
        if (rst_n && done === 1'b1)
        begin
            responses_seen++;
            if (outcomes_due.size() == 0)
                tally("response arrived with no request outstanding");
            else
            begin
                want = outcomes_due.pop_front();
                if (response.status !== want.rsp.status)
                    tally($sformatf("request %0d status: expected %0d, got %0d",
                                    want.seq, want.rsp.status, response.status));
                if (response.result_slot !== want.rsp.result_slot)
                    tally($sformatf("request %0d result_slot: expected %0d, got %0d",
                                    want.seq, want.rsp.result_slot, response.result_slot));
                if (response.result_tag !== want.rsp.result_tag)
                    tally($sformatf("request %0d result_tag: expected %h, got %h",
                                    want.seq, want.rsp.result_tag, response.result_tag));
                if (response.live_count !== want.rsp.live_count)
                    tally($sformatf("request %0d live_count: expected %0d, got %0d",
                                    want.seq, want.rsp.live_count, response.live_count));
            end
        end
    end

    initial
    begin
        req_t rq;
        int   fill_left;
        int   guard;
        start          = 1'b0;
        request        = '0;
        rst_n          = 1'b0;
        seq_no         = 0;
        mismatches     = 0;
        responses_seen = 0;
        free_all_seen  = 0;
        quiet_left     = 0;
        fill_left      = 0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        pool_reset();

        add_row(CMD_FIND,     0, 32'h0,        1'b1, ST_NOT_FOUND, 0, 32'h0, 0);
        add_row(CMD_FREE,     0, 32'h0,        1'b1, ST_NOT_LIVE,  0, 32'h0, 0);
        add_row(CMD_MOVE,    31, 32'hFFFFFFFF, 1'b1, ST_NOT_LIVE,  0, 32'h0, 0);
        add_row(CMD_FREE_ALL, 0, 32'h0,        1'b1, ST_OK,        0, 32'h0, 0);
        add_row(CMD_ALLOC,   31, 32'hFFFFFFFF, 1'b1, ST_OK,        0, 32'h0, 1);
        add_row(CMD_ALLOC,    0, 32'h0,        1'b1, ST_OK,        1, 32'h1, 2);
        add_row(CMD_ALLOC,    0, 32'h0,        1'b1, ST_OK,        2, 32'h2, 3);
        add_row(CMD_MOVE,     0, 32'h0,        1'b1, ST_OK,        0, 32'h0, 3);
        add_row(CMD_MOVE,     2, 32'h0,        1'b0, ST_OK,        0, 32'h0, 0);
        add_row(CMD_FIND,    31, 32'h1,        1'b1, ST_OK,        1, 32'h1, 3);
        add_row(CMD_FIND,     0, 32'hFFFFFFFF, 1'b1, ST_NOT_FOUND, 0, 32'h0, 3);
        add_row(CMD_FIND,     0, 32'h0,        1'b0, ST_OK,        0, 32'h0, 0);
        add_row(CMD_FREE,     0, 32'h0,        1'b0, ST_OK,        0, 32'h0, 0);
        add_row(CMD_ALLOC,    0, 32'h0,        1'b0, ST_OK,        0, 32'h0, 0);
        add_row(CMD_MOVE,     0, 32'h0,        1'b0, ST_OK,        0, 32'h0, 0);
        add_row(CMD_SPARE_A, 31, 32'hFFFFFFFF, 1'b1, ST_OK,        0, 32'h0, 3);
        add_row(CMD_SPARE_B,  0, 32'h3,        1'b1, ST_OK,        0, 32'h0, 3);
        add_row(CMD_SPARE_C, 31, 32'h0,        1'b1, ST_OK,        0, 32'h0, 3);
        add_row(CMD_FREE,     1, 32'h0,        1'b0, ST_OK,        0, 32'h0, 0);
        add_row(CMD_FREE,     1, 32'h0,        1'b1, ST_NOT_LIVE,  0, 32'h0, 2);
        add_row(CMD_FREE,    31, 32'h0,        1'b1, ST_NOT_LIVE,  0, 32'h0, 2);
        add_row(CMD_FREE_ALL, 0, 32'h0,        1'b1, ST_OK,        0, 32'h0, 0);
        add_row(CMD_FIND,     0, 32'h3,        1'b1, ST_NOT_FOUND, 0, 32'h0, 0);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[k])
            send(plan[k].rq, plan[k].typed, plan[k].want);
        drain();

        // The first random stretch starts by filling the pool past its capacity.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 0 || $urandom_range(0, 149) == 0)
                fill_left = SLOTS + 2;
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 199) == 0)
                quiet_left = $urandom_range(40, 150);
            if ($urandom_range(0, 59) == 0)
                drain();
            if (fill_left > 0)
            begin
                rq.command    = CMD_ALLOC;
                rq.slot       = FSLOT_W'($urandom_range(0, SLOTS - 1));
                rq.search_tag = $urandom();
                fill_left--;
            end
            else
                rq = pick_request();
            send(rq, 1'b0, '0);
        end

        start <= 1'b0;
        guard = 0;
        while (outcomes_due.size() != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (80) @(negedge clk);
        if (outcomes_due.size() != 0)
            tally($sformatf("%0d responses never arrived", outcomes_due.size()));

        $display("Ran %0d requests (%0d responses): %0d refused as full, %0d finds missed,",
                 seq_no, responses_seen, status_seen[int'(ST_FULL)],
                 status_seen[int'(ST_NOT_FOUND)]);
        $display("%0d refused as not live, %0d free-all sweeps; %0d mismatches.",
                 status_seen[int'(ST_NOT_LIVE)], free_all_seen, mismatches);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
